[design/dfpc_pkg.sv]
// ----------------------------------------------------------------------------
// dfpc_pkg
// Shared constants, tables and helper functions for the digit format
// preserving cipher core.
// ----------------------------------------------------------------------------
package dfpc_pkg;

  // Default values of the top level parameters.
  localparam int NUM_ROUNDS_DEF      = 10;
  localparam int MIN_DIGITS_DEF      = 2;
  localparam int MAX_DIGITS_DEF      = 18;
  localparam int MIN_TWEAK_BYTES_DEF = 0;
  localparam int MAX_TWEAK_BYTES_DEF = 11;

  // Field widths.
  localparam int HALF_W  = 30;
  localparam int KEY_W   = 64;
  localparam int Y_W     = 64;

  // Configuration register indexes.
  localparam logic [2:0] REG_KEY_WORD_0 = 3'd0;
  localparam logic [2:0] REG_KEY_WORD_1 = 3'd1;
  localparam logic [2:0] REG_KEY_WORD_2 = 3'd2;
  localparam logic [2:0] REG_KEY_WORD_3 = 3'd3;
  localparam logic [2:0] REG_KEY_MODE   = 3'd4;

  // Key size codes.
  localparam logic [1:0] KEY_MODE_128 = 2'd0;
  localparam logic [1:0] KEY_MODE_192 = 2'd1;
  localparam logic [1:0] KEY_MODE_256 = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_COUNT = 2'd1;
  localparam logic [1:0] ST_BAD_HALF  = 2'd2;
  localparam logic [1:0] ST_BAD_TWEAK = 2'd3;

  // Bytes of the fixed length block that change per request are filled in
  // by the core; the rest are these constants or zero (byte 0 first).
  localparam logic [7:0] FIX_B0 = 8'h01;
  localparam logic [7:0] FIX_B1 = 8'h02;
  localparam logic [7:0] FIX_B2 = 8'h01;
  localparam logic [7:0] FIX_B3 = 8'h0a;
  localparam logic [7:0] FIX_B6 = 8'h0a;

  // Number of round key rows for the largest key.
  localparam int RK_ROWS = 15;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // Multiply by x in GF(2^8).
  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Substitute the four bytes of a word.
  function automatic logic [31:0] subword(input logic [31:0] w);
    subword = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

  // Ten to the power d, held at 10^9 for larger d.
  function automatic logic [HALF_W-1:0] pow10(input logic [4:0] d);
    case (d)
      5'd0:    pow10 = 30'd1;
      5'd1:    pow10 = 30'd10;
      5'd2:    pow10 = 30'd100;
      5'd3:    pow10 = 30'd1000;
      5'd4:    pow10 = 30'd10000;
      5'd5:    pow10 = 30'd100000;
      5'd6:    pow10 = 30'd1000000;
      5'd7:    pow10 = 30'd10000000;
      5'd8:    pow10 = 30'd100000000;
      default: pow10 = 30'd1000000000;
    endcase
  endfunction

endpackage

[design/dfpc_mod.sv]
// ----------------------------------------------------------------------------
// dfpc_mod
// Bit-serial remainder of a 64-bit value by a modulus of up to 30 bits,
// one restoring step per cycle.
// ----------------------------------------------------------------------------
module dfpc_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [dfpc_pkg::Y_W-1:0]    dividend,
  input  logic [dfpc_pkg::HALF_W-1:0] modulus,
  output logic                        done,
  output logic [dfpc_pkg::HALF_W-1:0] remainder
);

  logic                        busy_r;
  logic [5:0]                  cnt_r;
  logic [dfpc_pkg::Y_W-1:0]    y_r;
  logic [dfpc_pkg::HALF_W-1:0] m_r;
  logic [dfpc_pkg::HALF_W-1:0] rem_r;
  logic                        done_r;
  logic [dfpc_pkg::HALF_W:0]   trial;
  logic [dfpc_pkg::HALF_W:0]   diff;
  logic [dfpc_pkg::HALF_W-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    trial = {rem_r, y_r[dfpc_pkg::Y_W-1]};
    diff  = trial - {1'b0, m_r};
    if (trial >= {1'b0, m_r}) begin
      rem_nxt = diff[dfpc_pkg::HALF_W-1:0];
    end else begin
      rem_nxt = trial[dfpc_pkg::HALF_W-1:0];
    end
  end

  // Step counter and datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        y_r    <= dividend;
        m_r    <= modulus;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        y_r   <= {y_r[dfpc_pkg::Y_W-2:0], 1'b0};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

[design/dfpc_aes.sv]
// ----------------------------------------------------------------------------
// dfpc_aes
// Iterative AES encryption engine: key expansion one word per cycle into a
// round key file, then one full round per cycle.
// ----------------------------------------------------------------------------
module dfpc_aes (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [255:0] key,
  input  logic [1:0]   key_mode,
  input  logic         key_start,
  input  logic         blk_start,
  input  logic [127:0] blk_in,
  output logic         done,
  output logic [127:0] blk_out
);

  typedef enum logic [1:0] {
    A_IDLE,
    A_KEXP,
    A_ENC
  } aes_state_t;

  aes_state_t   state_r;
  logic         done_r;
  logic [5:0]   wi_r;
  logic [2:0]   j_r;
  logic [7:0]   rc_r;
  logic [31:0]  sw_r [8];
  logic [95:0]  row_r;
  logic [127:0] rk_mem [dfpc_pkg::RK_ROWS];
  logic [3:0]   rnd_r;
  logic [127:0] st_r;

  logic [3:0]   nk;
  logic [3:0]   nr;
  logic [5:0]   last_word;
  logic [31:0]  key_word;
  logic [31:0]  sub_in;
  logic [31:0]  sub_out;
  logic [31:0]  t_word;
  logic [31:0]  new_word;
  logic [3:0]   back_idx;
  logic [127:0] rnd_out;
  logic [7:0]   sb [16];
  logic [7:0]   sr [16];
  logic [7:0]   mc [16];
  logic [127:0] mixed;

  // Key size decode; the unused fourth code acts as a 256-bit key.
  always_comb begin
    case (key_mode)
      dfpc_pkg::KEY_MODE_128: nk = 4'd4;
      dfpc_pkg::KEY_MODE_192: nk = 4'd6;
      default:                nk = 4'd8;
    endcase
    nr        = nk + 4'd6;
    last_word = {nr, 2'b11};
  end

  // Next round key word.
  always_comb begin
    key_word = key[{3'd7 - wi_r[2:0], 5'd0} +: 32];
    if (j_r == 3'd0) begin
      sub_in = {sw_r[7][23:0], sw_r[7][31:24]};
    end else begin
      sub_in = sw_r[7];
    end
    sub_out = dfpc_pkg::subword(sub_in);
    if (j_r == 3'd0) begin
      t_word = sub_out ^ {rc_r, 24'd0};
    end else if (nk == 4'd8 && j_r == 3'd4) begin
      t_word = sub_out;
    end else begin
      t_word = sw_r[7];
    end
    back_idx = 4'd8 - nk;
    if (wi_r < {2'b00, nk}) begin
      new_word = key_word;
    end else begin
      new_word = sw_r[back_idx[2:0]] ^ t_word;
    end
  end

  // One cipher round: SubBytes, ShiftRows, MixColumns (not in the last round)
  // and AddRoundKey.
  always_comb begin
    for (int k = 0; k < 16; k++) begin
      sb[k] = dfpc_pkg::SBOX[st_r[127-8*k -: 8]];
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        sr[4*c+i] = sb[4*((c+i)%4)+i];
      end
    end
    for (int c = 0; c < 4; c++) begin
      mc[4*c]   = dfpc_pkg::xt(sr[4*c]) ^ dfpc_pkg::xt(sr[4*c+1]) ^ sr[4*c+1]
                  ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c+1] = sr[4*c] ^ dfpc_pkg::xt(sr[4*c+1]) ^ dfpc_pkg::xt(sr[4*c+2])
                  ^ sr[4*c+2] ^ sr[4*c+3];
      mc[4*c+2] = sr[4*c] ^ sr[4*c+1] ^ dfpc_pkg::xt(sr[4*c+2])
                  ^ dfpc_pkg::xt(sr[4*c+3]) ^ sr[4*c+3];
      mc[4*c+3] = dfpc_pkg::xt(sr[4*c]) ^ sr[4*c] ^ sr[4*c+1] ^ sr[4*c+2]
                  ^ dfpc_pkg::xt(sr[4*c+3]);
    end
    for (int k = 0; k < 16; k++) begin
      mixed[127-8*k -: 8] = (rnd_r == nr) ? sr[k] : mc[k];
    end
    rnd_out = mixed ^ rk_mem[rnd_r];
  end

  // Sequencer, key file and state register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= A_IDLE;
      done_r  <= 1'b0;
      wi_r    <= '0;
      j_r     <= '0;
      rc_r    <= 8'h01;
      rnd_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        A_IDLE: begin
          if (key_start) begin
            state_r <= A_KEXP;
            wi_r    <= '0;
            j_r     <= '0;
            rc_r    <= 8'h01;
          end else if (blk_start) begin
            state_r <= A_ENC;
            st_r    <= blk_in ^ rk_mem[0];
            rnd_r   <= 4'd1;
          end
        end
        A_KEXP: begin
          for (int k = 0; k < 7; k++) begin
            sw_r[k] <= sw_r[k+1];
          end
          sw_r[7] <= new_word;
          row_r   <= {row_r[63:0], new_word};
          if (wi_r[1:0] == 2'b11) begin
            rk_mem[wi_r[5:2]] <= {row_r, new_word};
          end
          if (wi_r >= {2'b00, nk} && j_r == 3'd0) begin
            rc_r <= dfpc_pkg::xt(rc_r);
          end
          if ({1'b0, j_r} == nk - 4'd1) begin
            j_r <= '0;
          end else begin
            j_r <= j_r + 3'd1;
          end
          wi_r <= wi_r + 6'd1;
          if (wi_r == last_word) begin
            state_r <= A_IDLE;
            done_r  <= 1'b1;
          end
        end
        A_ENC: begin
          st_r  <= rnd_out;
          rnd_r <= rnd_r + 4'd1;
          if (rnd_r == nr) begin
            state_r <= A_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: state_r <= A_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign blk_out = st_r;

endmodule

[design/digit_format_preserving_cipher_core.sv]
// ----------------------------------------------------------------------------
// digit_format_preserving_cipher_core
// Encrypts or decrypts a decimal number held as two binary halves with a
// Feistel network over AES whose halves differ by at most one digit.
// ----------------------------------------------------------------------------
// One request is handled at a time. An accepted transaction runs a key
// expansion of 4*(Nr+1) round key words (Nr = 10, 12 or 14), one AES call on
// the length block and then NUM_ROUNDS rounded up to even Feistel rounds;
// each round is an AES call and a bit-serial remainder, sequenced by S_RSTART,
// S_RAES and S_RMOD. The time per request is set by the one-round-per-cycle
// AES engine and the serial remainder unit. A request that fails a check skips
// the rounds and passes through S_DONE to the output register once it is free.
// The input is accepted while a finished result still waits at the output.
module digit_format_preserving_cipher_core #(
  parameter int NUM_ROUNDS      = dfpc_pkg::NUM_ROUNDS_DEF,
  parameter int MIN_DIGITS      = dfpc_pkg::MIN_DIGITS_DEF,
  parameter int MAX_DIGITS      = dfpc_pkg::MAX_DIGITS_DEF,
  parameter int MIN_TWEAK_BYTES = dfpc_pkg::MIN_TWEAK_BYTES_DEF,
  parameter int MAX_TWEAK_BYTES = dfpc_pkg::MAX_TWEAK_BYTES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  // func[0], digit_count[5:1], head_value[35:6], tail_value[65:36],
  // tweak_head[129:66], tweak_tail[153:130], tweak_length[158:154]
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [159:0] in_tdata,
  // out_head[29:0], out_tail[59:30], status[61:60]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [63:0]  cfg_wdata
);

  localparam int PAIRS = (NUM_ROUNDS + 1) / 2;
  localparam int HALVES = 2 * PAIRS;
  localparam int HW = $clog2(HALVES);
  localparam logic [HW-1:0] LAST_HALF = HW'(HALVES - 1);
  localparam logic [7:0] IDX_TOP = 8'(HALVES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_KEXP,
    S_PMASK,
    S_RSTART,
    S_RAES,
    S_RMOD,
    S_DONE
  } seq_state_t;

  // Configuration registers.
  logic [63:0]  key0_r, key1_r, key2_r, key3_r;
  logic [1:0]   kmode_r;

  seq_state_t   state_r;
  logic         out_valid_r;
  logic [63:0]  out_data_r;
  logic         dec_r;
  logic [1:0]   status_r;
  logic [29:0]  a_r, b_r, ms_r, mb_r;
  logic [87:0]  twk_r;
  logic [127:0] pmask_r;
  logic [HW-1:0] half_r;
  logic         key_start_r, blk_start_r, mod_start_r;
  logic [127:0] blk_r;
  logic [63:0]  y_r;
  logic [29:0]  m_r;

  // Input fields.
  logic         f_dec;
  logic [4:0]   f_n;
  logic [29:0]  f_head, f_tail;
  logic [87:0]  f_tweak;
  logic [4:0]   f_tl;
  logic [4:0]   f_small, f_big;
  logic [29:0]  f_ms, f_mb, head_lim, tail_lim;
  logic [1:0]   f_status;
  logic [87:0]  f_twk_masked;
  logic [127:0] f_pblk;

  logic         aes_done, mod_done;
  logic [127:0] aes_out;
  logic [29:0]  mod_rem;
  logic [63:0]  aes_y;
  logic [127:0] round_blk;
  logic [7:0]   round_idx;
  logic [29:0]  other, target, cur_mod, upd;
  logic [31:0]  other_w;
  logic [30:0]  sum, sum_sub;

  assign f_dec   = in_tdata[0];
  assign f_n     = in_tdata[5:1];
  assign f_head  = in_tdata[35:6];
  assign f_tail  = in_tdata[65:36];
  assign f_tweak = in_tdata[153:66];
  assign f_tl    = in_tdata[158:154];

  // Request checks and the length block, evaluated on the incoming item.
  always_comb begin
    f_small  = {1'b0, f_n[4:1]};
    f_big    = f_n - f_small;
    f_ms     = dfpc_pkg::pow10(f_small);
    f_mb     = dfpc_pkg::pow10(f_big);
    head_lim = f_dec ? f_mb : f_ms;
    tail_lim = f_dec ? f_ms : f_mb;
    if (32'(f_n) < 32'(MIN_DIGITS) || 32'(f_n) > 32'(MAX_DIGITS)) begin
      f_status = dfpc_pkg::ST_BAD_COUNT;
    end else if (f_head >= head_lim || f_tail >= tail_lim) begin
      f_status = dfpc_pkg::ST_BAD_HALF;
    end else if (32'(f_tl) < 32'(MIN_TWEAK_BYTES) || 32'(f_tl) > 32'(MAX_TWEAK_BYTES)) begin
      f_status = dfpc_pkg::ST_BAD_TWEAK;
    end else begin
      f_status = dfpc_pkg::ST_OK;
    end
    // Tweak bytes at or beyond the tweak length read as zero.
    for (int k = 0; k < 11; k++) begin
      f_twk_masked[8*k +: 8] = (5'(k) < f_tl) ? f_tweak[8*k +: 8] : 8'h00;
    end
    f_pblk = {dfpc_pkg::FIX_B0, dfpc_pkg::FIX_B1, dfpc_pkg::FIX_B2, dfpc_pkg::FIX_B3,
              8'h00, 8'h00, dfpc_pkg::FIX_B6, {3'b000, f_small},
              {3'b000, f_n}, 8'h00, 8'h00, 8'h00,
              {3'b000, f_tl}, 8'h00, 8'h00, 8'h00};
  end

  // Round block: tweak, round index and the other half, masked by the
  // encrypted length block.
  always_comb begin
    round_idx = dec_r ? (IDX_TOP - 8'(half_r)) : 8'(half_r);
    other     = half_r[0] ? a_r : b_r;
    target    = half_r[0] ? b_r : a_r;
    cur_mod   = (half_r[0] ^ dec_r) ? mb_r : ms_r;
    other_w   = {2'b00, other};
    for (int k = 0; k < 11; k++) begin
      round_blk[127-8*k -: 8] = twk_r[8*k +: 8];
    end
    round_blk[127-8*11 -: 8] = round_idx;
    for (int k = 0; k < 4; k++) begin
      round_blk[127-8*(12+k) -: 8] = other_w[8*k +: 8];
    end
    round_blk = round_blk ^ pmask_r;
    for (int k = 0; k < 8; k++) begin
      aes_y[8*k +: 8] = aes_out[127-8*k -: 8];
    end
  end

  // Modular add for encryption, modular subtract for decryption.
  always_comb begin
    sum     = {1'b0, target} + {1'b0, mod_rem};
    sum_sub = {1'b0, target} - {1'b0, mod_rem};
    if (!dec_r) begin
      upd = (sum >= {1'b0, m_r}) ? 30'(sum - {1'b0, m_r}) : sum[29:0];
    end else if (target >= mod_rem) begin
      upd = sum_sub[29:0];
    end else begin
      upd = 30'(sum_sub + {1'b0, m_r});
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key0_r  <= '0;
      key1_r  <= '0;
      key2_r  <= '0;
      key3_r  <= '0;
      kmode_r <= dfpc_pkg::KEY_MODE_256;
    end else if (cfg_we) begin
      case (cfg_addr)
        dfpc_pkg::REG_KEY_WORD_0: key0_r  <= cfg_wdata;
        dfpc_pkg::REG_KEY_WORD_1: key1_r  <= cfg_wdata;
        dfpc_pkg::REG_KEY_WORD_2: key2_r  <= cfg_wdata;
        dfpc_pkg::REG_KEY_WORD_3: key3_r  <= cfg_wdata;
        dfpc_pkg::REG_KEY_MODE:   kmode_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  // Request sequencer and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      key_start_r <= 1'b0;
      blk_start_r <= 1'b0;
      mod_start_r <= 1'b0;
      half_r      <= '0;
    end else begin
      key_start_r <= 1'b0;
      blk_start_r <= 1'b0;
      mod_start_r <= 1'b0;
      // The result register empties when its transaction completes, unless
      // a new result is loaded in the same cycle.
      if (out_valid_r && out_tready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            dec_r    <= f_dec;
            status_r <= f_status;
            ms_r     <= f_ms;
            mb_r     <= f_mb;
            twk_r    <= f_twk_masked;
            blk_r    <= f_pblk;
            half_r   <= '0;
            if (f_status == dfpc_pkg::ST_OK) begin
              a_r         <= f_head;
              b_r         <= f_tail;
              key_start_r <= 1'b1;
              state_r     <= S_KEXP;
            end else begin
              a_r     <= '0;
              b_r     <= '0;
              state_r <= S_DONE;
            end
          end
        end
        S_KEXP: begin
          if (aes_done) begin
            blk_start_r <= 1'b1;
            state_r     <= S_PMASK;
          end
        end
        S_PMASK: begin
          if (aes_done) begin
            pmask_r <= aes_out;
            state_r <= S_RSTART;
          end
        end
        S_RSTART: begin
          blk_r       <= round_blk;
          m_r         <= cur_mod;
          blk_start_r <= 1'b1;
          state_r     <= S_RAES;
        end
        S_RAES: begin
          if (aes_done) begin
            y_r         <= aes_y;
            mod_start_r <= 1'b1;
            state_r     <= S_RMOD;
          end
        end
        S_RMOD: begin
          if (mod_done) begin
            if (half_r[0]) begin
              b_r <= upd;
            end else begin
              a_r <= upd;
            end
            half_r <= half_r + 1'b1;
            if (half_r == LAST_HALF) begin
              state_r <= S_DONE;
            end else begin
              state_r <= S_RSTART;
            end
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {2'b00, status_r, a_r, b_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  dfpc_aes u_aes (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       ({key0_r, key1_r, key2_r, key3_r}),
    .key_mode  (kmode_r),
    .key_start (key_start_r),
    .blk_start (blk_start_r),
    .blk_in    (blk_r),
    .done      (aes_done),
    .blk_out   (aes_out)
  );

  dfpc_mod u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start_r),
    .dividend  (y_r),
    .modulus   (m_r),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

[test/tb_digit_format_preserving_cipher_core.sv]
// ----------------------------------------------------------------------------
// tb_digit_format_preserving_cipher_core
// Self-checking bench for the digit format preserving cipher core. A queue
// of requests feeds a stream driver, and a behavioral AES/Feistel predictor
// computes each expected result at the moment its request is accepted. A
// monitor checks every result transaction field by field against the oldest
// expectation. The run covers several key sizes and key values.
// ----------------------------------------------------------------------------
module tb_digit_format_preserving_cipher_core;

  localparam logic [1:0] KEY_MODE_ALT = 2'd3;  // decodes as a 256-bit key
  localparam int HOLD_CYCLES = 4000;
  localparam int STALL_LIMIT = 40000;
  localparam int RAND_PER_PHASE = 325;

  typedef struct {
    bit        func;
    bit [4:0]  n;
    bit [29:0] head;
    bit [29:0] tail;
    bit [63:0] th;
    bit [23:0] tt;
    bit [4:0]  tl;
  } req_t;

  typedef struct {
    bit [29:0] head;
    bit [29:0] tail;
    bit [1:0]  status;
  } res_t;

  typedef bit [7:0] blk_t [16];

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [159:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [63:0]  out_tdata;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [63:0]  cfg_wdata;

  // Shadow copy of the key registers.
  bit [63:0] key_words [4];
  bit [1:0]  key_mode;
  bit [31:0] sched [60];
  int        aes_nr;

  req_t pending_reqs [$];
  res_t expected_res [$];
  int   mismatches;
  int   checked;
  int   ok_count;
  int   err_count;
  int   stall_cycles;
  bit   no_idle;
  bit   rx_hold_req;
  bit   rx_hold_taken;
  int   rx_hold_left;

  digit_format_preserving_cipher_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Doubling in GF(2^8).
  function automatic bit [7:0] gf_double(bit [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic bit [31:0] sub_bytes_word(bit [31:0] w);
    return {dfpc_pkg::SBOX[w[31:24]], dfpc_pkg::SBOX[w[23:16]],
            dfpc_pkg::SBOX[w[15:8]], dfpc_pkg::SBOX[w[7:0]]};
  endfunction

  // Expand the shadow key into round key words.
  function automatic void build_schedule();
    int nk;
    bit [7:0] rcon;
    bit [31:0] t;
    rcon = 8'h01;
    nk = (key_mode == dfpc_pkg::KEY_MODE_128) ? 4 :
         (key_mode == dfpc_pkg::KEY_MODE_192) ? 6 : 8;
    aes_nr = nk + 6;
    for (int i = 0; i < nk; i++)
      sched[i] = (i % 2 == 0) ? key_words[i/2][63:32] : key_words[i/2][31:0];
    for (int i = nk; i < 4 * (aes_nr + 1); i++) begin
      t = sched[i-1];
      if (i % nk == 0) begin
        t = sub_bytes_word({t[23:0], t[31:24]}) ^ {rcon, 24'h0};
        rcon = gf_double(rcon);
      end else if (nk > 6 && i % nk == 4) begin
        t = sub_bytes_word(t);
      end
      sched[i] = sched[i-nk] ^ t;
    end
  endfunction

  function automatic blk_t add_round_key(blk_t s, int r);
    for (int c = 0; c < 4; c++)
      for (int b = 0; b < 4; b++)
        s[4*c+b] ^= sched[4*r+c][31-8*b -: 8];
    return s;
  endfunction

  // One AES block encryption with the current schedule.
  function automatic blk_t aes_block_enc(blk_t s);
    blk_t t;
    bit [7:0] a0, a1, a2, a3;
    s = add_round_key(s, 0);
    for (int r = 1; r <= aes_nr; r++) begin
      for (int i = 0; i < 16; i++) t[i] = dfpc_pkg::SBOX[s[i]];
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) s[4*c+i] = t[4*((c+i)%4)+i];
      if (r != aes_nr) begin
        for (int c = 0; c < 4; c++) begin
          a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
          s[4*c]   = gf_double(a0) ^ gf_double(a1) ^ a1 ^ a2 ^ a3;
          s[4*c+1] = a0 ^ gf_double(a1) ^ gf_double(a2) ^ a2 ^ a3;
          s[4*c+2] = a0 ^ a1 ^ gf_double(a2) ^ gf_double(a3) ^ a3;
          s[4*c+3] = gf_double(a0) ^ a0 ^ a1 ^ a2 ^ gf_double(a3);
        end
      end
      s = add_round_key(s, r);
    end
    return s;
  endfunction

  function automatic bit [63:0] ten_pow(int d);
    bit [63:0] p;
    p = 1;
    for (int i = 0; i < ((d > 9) ? 9 : d); i++) p = p * 10;
    return p;
  endfunction

  // Feistel round function: AES of mask ^ (tweak, index, other half).
  function automatic bit [63:0] feistel_round(blk_t mask, blk_t tweak, int idx,
                                              bit [63:0] other, bit [63:0] modulus);
    blk_t s;
    bit [63:0] y;
    s = tweak;
    s[11] = idx[7:0];
    for (int i = 0; i < 4; i++) s[12+i] = other[8*i +: 8];
    for (int i = 0; i < 16; i++) s[i] ^= mask[i];
    s = aes_block_enc(s);
    y = 0;
    for (int i = 0; i < 8; i++) y[8*i +: 8] = s[i];
    return y % modulus;
  endfunction

  // Expected result of one request under the current key.
  function automatic res_t cipher_result(req_t q);
    res_t r;
    blk_t mask, tweak;
    int lo, hi, pairs;
    bit [63:0] ms, mb, a, b, y;
    r = '{head: 0, tail: 0, status: dfpc_pkg::ST_OK};
    if (q.n < dfpc_pkg::MIN_DIGITS_DEF || q.n > dfpc_pkg::MAX_DIGITS_DEF) begin
      r.status = dfpc_pkg::ST_BAD_COUNT;
      return r;
    end
    lo = q.n / 2;
    hi = q.n - lo;
    ms = ten_pow(lo);
    mb = ten_pow(hi);
    if (q.head >= (q.func ? mb : ms) || q.tail >= (q.func ? ms : mb)) begin
      r.status = dfpc_pkg::ST_BAD_HALF;
      return r;
    end
    if (q.tl < dfpc_pkg::MIN_TWEAK_BYTES_DEF || q.tl > dfpc_pkg::MAX_TWEAK_BYTES_DEF) begin
      r.status = dfpc_pkg::ST_BAD_TWEAK;
      return r;
    end
    build_schedule();
    mask = '{default: 8'h00};
    mask[0] = dfpc_pkg::FIX_B0; mask[1] = dfpc_pkg::FIX_B1;
    mask[2] = dfpc_pkg::FIX_B2; mask[3] = dfpc_pkg::FIX_B3;
    mask[6] = dfpc_pkg::FIX_B6;
    mask[7] = lo[7:0];
    mask[8] = {3'b000, q.n};
    mask[12] = {3'b000, q.tl};
    mask = aes_block_enc(mask);
    tweak = '{default: 8'h00};
    for (int k = 0; k < q.tl && k < 11; k++)
      tweak[k] = (k < 8) ? q.th[8*k +: 8] : q.tt[8*(k-8) +: 8];
    pairs = (dfpc_pkg::NUM_ROUNDS_DEF + 1) / 2;
    a = q.head;
    b = q.tail;
    if (!q.func) begin
      for (int i = 0; i < pairs; i++) begin
        a = (a + feistel_round(mask, tweak, 2*i, b, ms)) % ms;
        b = (b + feistel_round(mask, tweak, 2*i+1, a, mb)) % mb;
      end
    end else begin
      for (int i = pairs; i > 0; i--) begin
        y = feistel_round(mask, tweak, 2*i-1, b, mb);
        a = (a >= y) ? a - y : a + mb - y;
        y = feistel_round(mask, tweak, 2*i-2, a, ms);
        b = (b >= y) ? b - y : b + ms - y;
      end
    end
    r.head = b[29:0];
    r.tail = a[29:0];
    return r;
  endfunction

  // Random request: mostly well-formed, some with out-of-range fields.
  function automatic req_t random_req();
    req_t q;
    int lo, hi, kind;
    kind = $urandom_range(99);
    q.func = 1'($urandom_range(1));
    q.n = 5'($urandom_range(dfpc_pkg::MAX_DIGITS_DEF, dfpc_pkg::MIN_DIGITS_DEF));
    lo = q.n / 2;
    hi = q.n - lo;
    q.head = 30'($urandom_range(32'(ten_pow(q.func ? hi : lo) - 1)));
    q.tail = 30'($urandom_range(32'(ten_pow(q.func ? lo : hi) - 1)));
    q.th = {$urandom, $urandom};
    q.tt = 24'($urandom);
    q.tl = 5'($urandom_range(dfpc_pkg::MAX_TWEAK_BYTES_DEF));
    if (kind < 6) q.n = 5'($urandom);
    else if (kind < 12) q.head = 30'($urandom);
    else if (kind < 18) q.tail = 30'($urandom);
    else if (kind < 24) q.tl = 5'($urandom);
    return q;
  endfunction

  // Queue a request; a good encryption is followed by its decryption about one time in three.
  task automatic queue_random();
    req_t q, back;
    res_t r;
    q = random_req();
    pending_reqs.push_back(q);
    r = cipher_result(q);
    if (!q.func && r.status == dfpc_pkg::ST_OK && $urandom_range(2) == 0) begin
      back = q;
      back.func = 1'b1;
      back.head = r.head;
      back.tail = r.tail;
      pending_reqs.push_back(back);
    end
  endtask

  task automatic queue_req(bit f, int n, bit [29:0] h, bit [29:0] t, bit [63:0] th,
                           bit [23:0] tt, int tl);
    req_t q;
    q = '{func: f, n: 5'(n), head: h, tail: t, th: th, tt: tt, tl: 5'(tl)};
    pending_reqs.push_back(q);
  endtask

  // Register write; the block is idle whenever this is called.
  task automatic write_reg(bit [2:0] idx, bit [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    if (idx == dfpc_pkg::REG_KEY_MODE) key_mode = value[1:0];
    else key_words[idx[1:0]] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_key(bit [1:0] mode, bit [63:0] k0, bit [63:0] k1,
                          bit [63:0] k2, bit [63:0] k3);
    write_reg(dfpc_pkg::REG_KEY_WORD_0, k0);
    write_reg(dfpc_pkg::REG_KEY_WORD_1, k1);
    write_reg(dfpc_pkg::REG_KEY_WORD_2, k2);
    write_reg(dfpc_pkg::REG_KEY_WORD_3, k3);
    write_reg(dfpc_pkg::REG_KEY_MODE, {62'h0, mode});
  endtask

  // Wait until every queued request has been answered.
  task automatic drain();
    @(negedge clk);
    while (pending_reqs.size() != 0 || expected_res.size() != 0) @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) queue_random();
    drain();
  endtask

  // Stimulus sequence.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    rx_hold_req = 1'b0;
    key_words = '{default: 64'h0};
    key_mode = dfpc_pkg::KEY_MODE_256;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed requests under the reset key.
    queue_req(0, 2, 0, 0, 64'h0, 24'h0, 0);
    queue_req(1, 2, 9, 9, 64'h0, 24'h0, 0);
    queue_req(0, 18, 999999999, 999999999, '1, '1, 11);
    queue_req(1, 18, 999999999, 999999999, '1, '1, 11);
    queue_req(0, 17, 99999999, 999999999, 64'h0123456789abcdef, 24'habcdef, 8);
    queue_req(1, 17, 999999999, 99999999, 64'h0123456789abcdef, 24'habcdef, 8);
    queue_req(0, 3, 5, 42, 64'hffffffffffffffff, 24'hffffff, 0);
    queue_req(0, 0, 0, 0, 64'h0, 24'h0, 0);
    queue_req(1, 1, 0, 0, 64'h0, 24'h0, 0);
    queue_req(0, 19, 0, 0, 64'h0, 24'h0, 0);
    queue_req(1, 31, '1, '1, '1, '1, 31);
    queue_req(0, 10, 100000, 0, 64'h0, 24'h0, 5);
    queue_req(0, 10, 0, 100000, 64'h0, 24'h0, 5);
    queue_req(1, 11, 1000000, 0, 64'h0, 24'h0, 5);
    queue_req(1, 11, 0, 100000, 64'h0, 24'h0, 5);
    queue_req(0, 4, '1, 0, 64'h0, 24'h0, 31);
    queue_req(0, 4, 12, 34, 64'h0, 24'h0, 12);
    queue_req(1, 4, 12, 34, 64'h0, 24'h0, 16);
    queue_req(0, 6, 999, 999, 64'haaaaaaaaaaaaaaaa, 24'h555555, 1);
    queue_req(1, 6, 999, 999, 64'h5555555555555555, 24'haaaaaa, 10);
    drain();

    load_key(dfpc_pkg::KEY_MODE_128, {$urandom, $urandom}, {$urandom, $urandom},
             64'h0, 64'h0);
    random_phase(RAND_PER_PHASE);

    // Long output stall while requests keep coming.
    load_key(dfpc_pkg::KEY_MODE_192, '1, '1, '1, '1);
    @(posedge clk);
    rx_hold_req <= 1'b1;
    random_phase(RAND_PER_PHASE);

    no_idle = 1'b1;
    load_key(dfpc_pkg::KEY_MODE_256, {$urandom, $urandom}, {$urandom, $urandom},
             {$urandom, $urandom}, {$urandom, $urandom});
    random_phase(RAND_PER_PHASE);
    no_idle = 1'b0;

    load_key(KEY_MODE_ALT, {$urandom, $urandom}, 64'h0, '1, {$urandom, $urandom});
    random_phase(RAND_PER_PHASE);

    load_key(dfpc_pkg::KEY_MODE_128, '1, '1, 64'h0, 64'h0);
    random_phase(RAND_PER_PHASE);

    repeat (50) @(posedge clk);
    if (expected_res.size() != 0) mismatches++;
    $display("Checked %0d results (%0d encrypted or decrypted, %0d rejected) over",
             checked, ok_count, err_count);
    $display("  all key sizes, zero and all-ones keys, stalls and bursts.");
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Request driver: keeps tvalid high until the transaction completes.
  always @(posedge clk) begin
    bit taken;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      taken = in_tvalid && in_tready;
      if (taken) begin
        expected_res.push_back(cipher_result(pending_reqs[0]));
        void'(pending_reqs.pop_front());
      end
      if (in_tvalid && !taken) begin
        in_tvalid <= 1'b1;
      end else if (pending_reqs.size() != 0 &&
                   (no_idle || $urandom_range(99) >= 12)) begin
        in_tvalid <= 1'b1;
        in_tdata <= {1'b0, pending_reqs[0].tl, pending_reqs[0].tt, pending_reqs[0].th,
                     pending_reqs[0].tail, pending_reqs[0].head, pending_reqs[0].n,
                     pending_reqs[0].func};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver with random backpressure and one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_hold_taken <= 1'b0;
      rx_hold_left <= 0;
    end else if (rx_hold_req && !rx_hold_taken) begin
      rx_hold_taken <= 1'b1;
      rx_hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || $urandom_range(99) >= 12;
    end
  end

  // Result checker.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      checked++;
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result transaction %h", out_tdata);
      end else begin
        want = expected_res.pop_front();
        if (want.status == dfpc_pkg::ST_OK) ok_count++;
        else err_count++;
        if (out_tdata[29:0] !== want.head || out_tdata[59:30] !== want.tail ||
            out_tdata[61:60] !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: head %0d/%0d tail %0d/%0d status %0d/%0d (exp/act)",
                     want.head, out_tdata[29:0], want.tail, out_tdata[59:30],
                     want.status, out_tdata[61:60]);
        end
      end
    end
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d idle cycles", stall_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

endmodule

[digit_format_preserving_cipher_core.f]
design/dfpc_pkg.sv
design/dfpc_mod.sv
design/dfpc_aes.sv
design/digit_format_preserving_cipher_core.sv
test/tb_digit_format_preserving_cipher_core.sv
